/* rtl/button_debounce_long_press_defines.svh */
// Assertion macros shared by the button debounce RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BDLP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define BDLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bdlp_pkg.sv */
// Package for the button debounce / long-press block: event codes,
// register indexes, reset values and the result record. No dependencies.
`timescale 1ns / 1ps

package bdlp_pkg;

    // Event codes reported with each sample
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } press_event_t;

    // Configuration register indexes
    localparam logic CFG_IDX_DEBOUNCE   = 1'b0;
    localparam logic CFG_IDX_LONG_PRESS = 1'b1;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned TIME_W     = 32;

    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_MS_RESET   = 16'd30;
    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_MS_RESET = 16'd1000;

    // One result item
    typedef struct packed {
        logic [1:0] press_event;
        logic       debounced_level;
    } result_t;

endpackage

/* rtl/button_debounce_long_press.sv */
// Button debounce with long-press detection, top level.
// Depends on bdlp_pkg and button_debounce_long_press_defines.svh.
`timescale 1ns / 1ps
// Each transfer on the input channel is one sample (raw level plus a 32-bit
// millisecond timestamp) and yields exactly one result transfer carrying an
// event code (none, short press on release, long press) and the debounced
// level. A sample is processed in the cycle it is accepted: one subtract and
// compare per timer feeds the state registers and a two-entry result queue
// (output register plus skid register), so one sample per clock is taken
// while the skid is empty; input stalls only when both entries are full.
// Timing uses 32-bit wraparound differences; the user writes debounce_ms
// (index 0) and long_press_ms (index 1) via cfg only while idle, unenforced.

`include "button_debounce_long_press_defines.svh"

module button_debounce_long_press
    import bdlp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration writes
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // Sample channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  button_pressed,
    input  logic [TIME_W-1:0]     now_ms,

    // Result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            press_event,
    output logic                  debounced_level
);

    // Configuration registers
    logic [CFG_DATA_W-1:0] debounce_ms_reg;
    logic [CFG_DATA_W-1:0] long_press_ms_reg;

    // Debounce state
    logic              last_raw_reg, last_raw_next;
    logic              stable_level_reg, stable_level_next;
    logic              long_done_reg, long_done_next;
    logic [TIME_W-1:0] change_time_reg, change_time_next;
    logic [TIME_W-1:0] press_time_reg, press_time_next;

    // Result queue
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;

    logic              in_fire;
    logic              out_fire;
    logic              raw_changed;
    logic              level_accept;
    logic              press_accept;
    logic [TIME_W-1:0] steady_ms;
    logic [TIME_W-1:0] held_ms;
    logic              long_fire;
    press_event_t      ev;
    result_t           result;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = main_valid_reg && out_ready;

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg   <= DEBOUNCE_MS_RESET;
            long_press_ms_reg <= LONG_PRESS_MS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IDX_DEBOUNCE:   debounce_ms_reg   <= cfg_data;
                CFG_IDX_LONG_PRESS: long_press_ms_reg <= cfg_data;
                default:            debounce_ms_reg   <= debounce_ms_reg;
            endcase
        end
    end

    // Sample processing: debounce timer, then long-press timer
    always_comb
    begin
        raw_changed   = (button_pressed != last_raw_reg);
        last_raw_next = button_pressed;
        change_time_next = raw_changed ? now_ms : change_time_reg;
        // a fresh raw change has been steady for zero ms
        steady_ms = raw_changed ? '0 : (now_ms - change_time_reg);

        level_accept = (button_pressed != stable_level_reg)
                    && (steady_ms >= {{(TIME_W-CFG_DATA_W){1'b0}}, debounce_ms_reg});
        press_accept = level_accept && button_pressed;

        stable_level_next = level_accept ? button_pressed : stable_level_reg;
        press_time_next   = press_accept ? now_ms : press_time_reg;
        held_ms           = press_accept ? '0 : (now_ms - press_time_reg);

        ev             = EV_NONE;
        long_done_next = press_accept ? 1'b0 : long_done_reg;
        if (level_accept && !button_pressed && !long_done_reg)
        begin
            ev = EV_SHORT;
        end

        long_fire = stable_level_next && !long_done_next
                 && (held_ms >= {{(TIME_W-CFG_DATA_W){1'b0}}, long_press_ms_reg});
        if (long_fire)
        begin
            long_done_next = 1'b1;
            ev             = EV_LONG;
        end

        result.press_event     = ev;
        result.debounced_level = stable_level_next;
    end

    // State update on each accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg     <= 1'b0;
            stable_level_reg <= 1'b0;
            long_done_reg    <= 1'b0;
            change_time_reg  <= '0;
            press_time_reg   <= '0;
        end
        else if (in_fire)
        begin
            last_raw_reg     <= last_raw_next;
            stable_level_reg <= stable_level_next;
            long_done_reg    <= long_done_next;
            change_time_reg  <= change_time_next;
            press_time_reg   <= press_time_next;
        end
    end

    // Result queue: output register with a skid entry behind it
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        priority if (skid_valid_reg)
        begin
            // input is stalled while the skid entry is full
            if (out_fire)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (!main_valid_reg || out_fire)
            begin
                main_next       = result;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid       = main_valid_reg;
    assign press_event     = main_reg.press_event;
    assign debounced_level = main_reg.debounced_level;

    // Checks
    `BDLP_ASSERT_SAME(a_skid_behind_main, clk, rst_n, skid_valid_reg, main_valid_reg, "skid entry held with empty output register")
    `BDLP_ASSERT_SAME(a_long_while_pressed, clk, rst_n, out_valid && (press_event == EV_LONG), debounced_level, "long press reported while released")
    `BDLP_ASSERT_SAME(a_short_on_release, clk, rst_n, out_valid && (press_event == EV_SHORT), !debounced_level, "short press reported while pressed")
    `BDLP_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_fire, out_valid, "accepted sample produced no result")

endmodule

/* verif/button_debounce_long_press_test.sv */
// Self-checking testbench for button_debounce_long_press: directed table, then
// randomized press/release sequences checked against a behavioral predictor.
// Depends on bdlp_pkg and the button_debounce_long_press RTL.
`timescale 1ns / 1ps

module button_debounce_long_press_test;
    import bdlp_pkg::*;

    localparam int SCRIPT_LEN   = 28;
    localparam int RANDOM_ITEMS = 1900;
    localparam int PHASES       = 8;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_CFG
    } row_kind_t;

    // One row of the directed table: a sample with its expected result,
    // or a timer setting
    typedef struct packed {
        row_kind_t               kind;
        logic                    raw;
        logic [TIME_W-1:0]       now;
        press_event_t            ev;
        logic                    level;
        logic [CFG_DATA_W-1:0]   deb;
        logic [CFG_DATA_W-1:0]   hold;
    } script_row_t;

    logic                  clk             = 1'b0;
    logic                  rst_n           = 1'b0;
    logic                  cfg_write       = 1'b0;
    logic                  cfg_index       = CFG_IDX_DEBOUNCE;
    logic [CFG_DATA_W-1:0] cfg_data        = '0;
    logic                  in_valid        = 1'b0;
    logic                  in_ready;
    logic                  button_pressed  = 1'b0;
    logic [TIME_W-1:0]     now_ms          = '0;
    logic                  out_valid;
    logic                  out_ready       = 1'b0;
    logic [1:0]            press_event;
    logic                  debounced_level;

    // Fixed expectation travelling with a directed sample
    logic                  fixed_exp       = 1'b0;
    result_t               fixed_result    = '0;

    // Predictor copy of the timers and block state
    logic [31:0]           debounce_ms     = 32'(DEBOUNCE_MS_RESET);
    logic [31:0]           long_press_ms   = 32'(LONG_PRESS_MS_RESET);
    logic                  raw_seen        = 1'b0;
    logic                  level_q         = 1'b0;
    logic                  long_hit        = 1'b0;
    logic [31:0]           t_change        = '0;
    logic [31:0]           t_press         = '0;

    result_t               pending_results[$];
    int                    bad_results     = 0;
    int                    samples_sent    = 0;
    int                    stall_left      = 0;
    logic [31:0]           t_now           = '0;
    bit                    quiet_sender    = 1'b0;
    bit                    quiet_receiver  = 1'b0;

    script_row_t           script [SCRIPT_LEN];

    button_debounce_long_press u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .button_pressed  (button_pressed),
        .now_ms          (now_ms),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .press_event     (press_event),
        .debounced_level (debounced_level)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Debounce / long-press prediction for one accepted sample
    function automatic result_t predict_sample(logic raw, logic [31:0] now);
        result_t r;
        r.press_event = EV_NONE;
        if (raw != raw_seen)
        begin
            raw_seen = raw;
            t_change = now;
        end
        if (raw != level_q && (now - t_change) >= debounce_ms)
        begin
            level_q = raw;
            if (level_q)
            begin
                t_press  = now;
                long_hit = 1'b0;
            end
            else if (!long_hit)
                r.press_event = EV_SHORT;
        end
        // long press fires once per debounced hold
        if (level_q && !long_hit && (now - t_press) >= long_press_ms)
        begin
            long_hit      = 1'b1;
            r.press_event = EV_LONG;
        end
        r.debounced_level = level_q;
        return r;
    endfunction

    // Step size for a hold: mostly spread out, sometimes exactly a threshold
    function automatic logic [31:0] pick_dt();
        int unsigned span;
        int unsigned r;
        span = ((debounce_ms > long_press_ms) ? debounce_ms : long_press_ms) / 3 + 1;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, span);
        if (r < 65)
            return 0;
        if (r < 80)
            return debounce_ms;
        if (r < 90)
            return long_press_ms;
        return 1;
    endfunction

    // Sample and result transfers; expectation queued at acceptance
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                want = predict_sample(button_pressed, now_ms);
                if (fixed_exp)
                    want = fixed_result;
                pending_results.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                got.press_event     = press_event;
                got.debounced_level = debounced_level;
                if (pending_results.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= MAX_REPORTS)
                        $display("%0t: unexpected result event=%0d level=%0b",
                                 $time, press_event, debounced_level);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        bad_results++;
                        if (bad_results <= MAX_REPORTS)
                            $display("%0t: expected event=%0d level=%0b, %s%0d level=%0b",
                                     $time, want.press_event, want.debounced_level,
                                     "got event=", got.press_event,
                                     got.debounced_level);
                    end
                end
            end
        end
    end

    // Result-side backpressure: short random stalls, occasional long ones
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!quiet_receiver && $urandom_range(0, 99) < 2)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(8, 40);
        end
        else
            out_ready <= quiet_receiver || ($urandom_range(0, 99) < 70);
    end

    // One sample transfer, with an optional gap in front
    task automatic send_sample(logic raw, logic [31:0] now, logic fixed, result_t fixed_val);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (quiet_sender || r < 60)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        button_pressed <= raw;
        now_ms         <= now;
        fixed_exp      <= fixed;
        fixed_result   <= fixed_val;
        do
            @(posedge clk);
        while (!in_ready);
        samples_sent++;
    endtask

    task automatic emit(logic raw, logic [31:0] dt);
        t_now = t_now + dt;
        send_sample(raw, t_now, 1'b0, '0);
    endtask

    // Stop sending and let every expected result drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both timers on consecutive edges
    task automatic program_timers(logic [CFG_DATA_W-1:0] deb, logic [CFG_DATA_W-1:0] hold);
        cfg_write <= 1'b1;
        cfg_index <= CFG_IDX_DEBOUNCE;
        cfg_data  <= deb;
        @(posedge clk);
        cfg_index <= CFG_IDX_LONG_PRESS;
        cfg_data  <= hold;
        @(posedge clk);
        cfg_write     <= 1'b0;
        debounce_ms   = 32'(deb);
        long_press_ms = 32'(hold);
    endtask

    // Contact bounce followed by a steady run at the target level
    task automatic settle_to(logic level);
        int bounces;
        int holds;
        bounces = $urandom_range(0, 4);
        holds   = $urandom_range(1, 12);
        for (int k = 0; k < bounces; k++)
            emit(level ^ k[0], $urandom_range(0, (debounce_ms >> 1) + 1));
        repeat (holds) emit(level, pick_dt());
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] deb;
        logic [CFG_DATA_W-1:0] hold;
        int                    phase_end;
        int                    pick;

        script = '{
            // reset timers: 30 ms debounce, 1000 ms long press
            '{ROW_SAMPLE, 1'b0, 32'd0,          EV_NONE,  1'b0, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b1, 32'd100,        EV_NONE,  1'b0, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b1, 32'd129,        EV_NONE,  1'b0, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b1, 32'd130,        EV_NONE,  1'b1, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b0, 32'd200,        EV_NONE,  1'b1, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b0, 32'd230,        EV_SHORT, 1'b0, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b1, 32'd300,        EV_NONE,  1'b0, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b1, 32'd330,        EV_NONE,  1'b1, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b1, 32'd1329,       EV_NONE,  1'b1, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b1, 32'd1330,       EV_LONG,  1'b1, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b0, 32'd1400,       EV_NONE,  1'b1, 16'd0, 16'd0},
            // release after a long press reports nothing
            '{ROW_SAMPLE, 1'b0, 32'd1430,       EV_NONE,  1'b0, 16'd0, 16'd0},
            // debounce across the timestamp wrap
            '{ROW_SAMPLE, 1'b1, 32'hFFFF_FFF0,  EV_NONE,  1'b0, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b1, 32'h0000_000E,  EV_NONE,  1'b1, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b0, 32'h0000_0010,  EV_NONE,  1'b1, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b0, 32'h0000_002E,  EV_SHORT, 1'b0, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b0, 32'hFFFF_FFFF,  EV_NONE,  1'b0, 16'd0, 16'd0},
            // zero debounce: a change is taken on the same sample
            '{ROW_CFG,    1'b0, 32'd0,          EV_NONE,  1'b0, 16'd0, 16'd1000},
            '{ROW_SAMPLE, 1'b1, 32'd500,        EV_NONE,  1'b1, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b0, 32'd505,        EV_SHORT, 1'b0, 16'd0, 16'd0},
            // zero long-press: fires on the accepting sample
            '{ROW_CFG,    1'b0, 32'd0,          EV_NONE,  1'b0, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b1, 32'd510,        EV_LONG,  1'b1, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b0, 32'd511,        EV_NONE,  1'b0, 16'd0, 16'd0},
            // largest timers
            '{ROW_CFG,    1'b0, 32'd0,          EV_NONE,  1'b0, 16'hFFFF, 16'hFFFF},
            '{ROW_SAMPLE, 1'b1, 32'h8000_0000,  EV_NONE,  1'b0, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b1, 32'h8000_FFFE,  EV_NONE,  1'b0, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b1, 32'h8000_FFFF,  EV_NONE,  1'b1, 16'd0, 16'd0},
            '{ROW_SAMPLE, 1'b1, 32'h8001_FFFE,  EV_LONG,  1'b1, 16'd0, 16'd0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
            begin
                wait_idle();
                program_timers(script[i].deb, script[i].hold);
            end
            else
                send_sample(script[i].raw, script[i].now, 1'b1,
                            result_t'({script[i].ev, script[i].level}));
        end

        // Random phases, each with its own timer setting
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                0: begin deb = 16'd1;               hold = 16'd1;               end
                1: begin deb = 16'hFFFF;            hold = 16'hFFFF;            end
                2: begin deb = 16'd0;               hold = 16'd0;               end
                3: begin deb = DEBOUNCE_MS_RESET;   hold = LONG_PRESS_MS_RESET; end
                4: begin deb = 16'hFFFF;            hold = 16'd1;               end
                5: begin deb = 16'd1;               hold = 16'hFFFF;            end
                default:
                begin
                    deb  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                       : 16'($urandom_range(0, 200));
                    hold = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                       : 16'($urandom_range(0, 2000));
                end
            endcase
            program_timers(deb, hold);
            t_now = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200000)
                                                : $urandom();
            phase_end = samples_sent + RANDOM_ITEMS / PHASES;
            while (samples_sent < phase_end)
            begin
                quiet_sender   = ($urandom_range(0, 5) == 0);
                quiet_receiver = ($urandom_range(0, 5) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    // full press and release
                    settle_to(1'b1);
                    settle_to(1'b0);
                end
                else if (pick < 90)
                    emit(1'($urandom_range(0, 1)), $urandom_range(0, 2 * debounce_ms + 2));
                else
                begin
                    // time jump to anywhere
                    t_now = $urandom();
                    emit(1'($urandom_range(0, 1)), 0);
                end
            end
        end

        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
        wait_idle();
        if (bad_results == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/bdlp_pkg.sv
rtl/button_debounce_long_press.sv
verif/button_debounce_long_press_test.sv
